// ===== rtl/frma_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame-rate moving average: shared package
// Window size, derived widths and the divider request and response bundles.
// ----------------------------------------------------------------------------
package frma_pkg;

	localparam int WINDOW    = 10;
	localparam int SLOT_W    = $clog2(WINDOW);
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int TICK_W    = 32;
	localparam int TPS_W     = 20;
	localparam int FRAC_W    = 8;
	localparam int RATE_W    = 32;
	localparam int FRAMES_W  = 4;
	localparam int SUM_W     = TICK_W + $clog2(WINDOW);
	localparam int PROD_W    = TPS_W + CNT_W;
	localparam int DVD_W     = PROD_W + FRAC_W;
	localparam int DCNT_W    = $clog2(DVD_W);

	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

	typedef struct packed {
		logic               start;
		logic [DVD_W-1:0]   dividend;
		logic [SUM_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DVD_W-1:0]   quotient;
	} div_rsp_t;

endpackage

// ===== rtl/frma_div.sv =====
// ----------------------------------------------------------------------------
// Frame-rate moving average: sequential divider
// Restoring division, one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module frma_div (
	input  logic                clk,
	input  logic                arst_n,
	input  frma_pkg::div_req_t  req,
	output frma_pkg::div_rsp_t  rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [frma_pkg::DCNT_W-1:0]    cnt_q;
	logic [frma_pkg::DVD_W-1:0]     dq_q;
	logic [frma_pkg::SUM_W-1:0]     rem_q;
	logic [frma_pkg::SUM_W-1:0]     divisor_q;
	logic [frma_pkg::SUM_W:0]       rem_sh;
	logic [frma_pkg::SUM_W:0]       diff;

	assign rem_sh = {rem_q, dq_q[frma_pkg::DVD_W-1]};
	assign diff   = rem_sh - {1'b0, divisor_q};

	// dq_q holds the unused dividend bits on top and collects quotient bits below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			dq_q      <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q    <= 1'b1;
				cnt_q     <= frma_pkg::DCNT_W'(frma_pkg::DVD_W - 1);
				dq_q      <= req.dividend;
				rem_q     <= '0;
				divisor_q <= req.divisor;
			end else if (busy_q) begin
				if (!diff[frma_pkg::SUM_W]) begin
					rem_q <= diff[frma_pkg::SUM_W-1:0];
					dq_q  <= {dq_q[frma_pkg::DVD_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[frma_pkg::SUM_W-1:0];
					dq_q  <= {dq_q[frma_pkg::DVD_W-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

`ifndef SYNTHESIS
	a_no_start_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == '0 |=> done_q && !busy_q)
		else $error("divider did not finish after its last step");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a preceding run");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < divisor_q)
		else $error("partial remainder not below divisor");
`endif

endmodule

// ===== rtl/frame_rate_moving_average_top.sv =====
// ----------------------------------------------------------------------------
// Frame-rate moving average
// Keeps the last frame durations in a small ring memory with a running sum
// and reports count * ticks_per_second * 256 / sum as the frame rate.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   ------------------------------------------
//  input     in_valid / in_stall    tick_now, restart
//  output    out_valid / out_stall  rate_q8, frames_in_window, saturated
//  config    cfg_wr_en              cfg_wr_data (ticks_per_second)
//
// A frame beat goes through ST_UPD for the update and write-back, ST_MUL to
// form the product and load the divider, ST_DIV for the 32 divider steps and
// taking the quotient, and ST_FIN to load the output register, where it waits
// while a held result is stalled. The next beat is taken back in ST_IDLE.
// A zero sum skips the divider; a restart goes straight to ST_FIN.
// One beat is worked on at a time; a finished result waits in the output
// register while the next beat is taken. Reset clears the history and sets
// ticks_per_second to 1000; the ring memory itself is never cleared.
// ----------------------------------------------------------------------------
module frame_rate_moving_average_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [frma_pkg::TPS_W-1:0]          cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [frma_pkg::TICK_W-1:0]         tick_now,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [frma_pkg::RATE_W-1:0]         rate_q8,
	output logic [frma_pkg::FRAMES_W-1:0]       frames_in_window,
	output logic                                saturated
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                             state_q;
	logic [frma_pkg::TPS_W-1:0]         tps_q;
	logic [frma_pkg::TICK_W-1:0]        tick_q;
	logic [frma_pkg::TICK_W-1:0]        last_tick_q;
	logic [frma_pkg::SLOT_W-1:0]        slot_q;
	logic [frma_pkg::CNT_W-1:0]         filled_q;
	logic [frma_pkg::SUM_W-1:0]         sum_q;
	logic [frma_pkg::RATE_W-1:0]        res_rate_q;
	logic                               res_sat_q;
	logic                               out_valid_q;
	logic [frma_pkg::RATE_W-1:0]        out_rate_q;
	logic [frma_pkg::FRAMES_W-1:0]      out_frames_q;
	logic                               out_sat_q;

	logic [frma_pkg::TICK_W-1:0]        ring_mem [frma_pkg::WINDOW];
	logic [frma_pkg::TICK_W-1:0]        rd_data_q;

	logic                               in_accept;
	logic                               full;
	logic [frma_pkg::TICK_W-1:0]        delta;
	logic [frma_pkg::TICK_W-1:0]        old_dur;
	logic [frma_pkg::PROD_W-1:0]        product;
	logic [frma_pkg::DVD_W:0]           quot_ext;
	logic                               quot_over;
	frma_pkg::div_req_t                 div_req;
	frma_pkg::div_rsp_t                 div_rsp;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// While the ring is not yet full, the slot about to be written was never
	// written since the last restart and counts as zero.
	assign full    = (filled_q == frma_pkg::CNT_W'(frma_pkg::WINDOW));
	assign old_dur = full ? rd_data_q : '0;
	assign delta   = tick_q - last_tick_q;
	assign product = frma_pkg::PROD_W'(tps_q) * frma_pkg::PROD_W'(filled_q);

	assign div_req.start    = (state_q == ST_MUL) && (sum_q != '0);
	assign div_req.dividend = {product, frma_pkg::FRAC_W'(0)};
	assign div_req.divisor  = sum_q;

	assign quot_ext  = {1'b0, div_rsp.quotient};
	assign quot_over = quot_ext > (frma_pkg::DVD_W + 1)'({frma_pkg::RATE_W{1'b1}});

	frma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			ring_mem[slot_q] <= delta;
		end
		if (in_accept) begin
			rd_data_q <= ring_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tps_q        <= frma_pkg::TPS_RESET;
			tick_q       <= '0;
			last_tick_q  <= '0;
			slot_q       <= '0;
			filled_q     <= '0;
			sum_q        <= '0;
			res_rate_q   <= '0;
			res_sat_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_rate_q   <= '0;
			out_frames_q <= '0;
			out_sat_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tps_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (restart) begin
							last_tick_q <= tick_now;
							slot_q      <= '0;
							filled_q    <= '0;
							sum_q       <= '0;
							res_rate_q  <= '0;
							res_sat_q   <= 1'b0;
							state_q     <= ST_FIN;
						end else begin
							tick_q  <= tick_now;
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					last_tick_q <= tick_q;
					sum_q       <= sum_q - frma_pkg::SUM_W'(old_dur)
					               + frma_pkg::SUM_W'(delta);
					if (slot_q == frma_pkg::SLOT_W'(frma_pkg::WINDOW - 1)) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
					if (!full) begin
						filled_q <= filled_q + 1'b1;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (sum_q == '0) begin
						res_rate_q <= '1;
						res_sat_q  <= 1'b1;
						state_q    <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						res_rate_q <= quot_over ? '1 : frma_pkg::RATE_W'(div_rsp.quotient);
						res_sat_q  <= quot_over;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_rate_q   <= res_rate_q;
						out_frames_q <= frma_pkg::FRAMES_W'(filled_q);
						out_sat_q    <= res_sat_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign rate_q8          = out_rate_q;
	assign frames_in_window = out_frames_q;
	assign saturated        = out_sat_q;

`ifndef SYNTHESIS
	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> frma_pkg::CNT_W'(slot_q) == filled_q)
		else $error("write slot out of step with fill count");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= frma_pkg::CNT_W'(frma_pkg::WINDOW))
		else $error("fill count beyond window");

	a_sat_means_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_sat_q |-> out_rate_q == {frma_pkg::RATE_W{1'b1}})
		else $error("saturated result without maximum rate");

	a_restart_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_frames_q == '0 |-> out_rate_q == '0 && !out_sat_q)
		else $error("restart result not zero");

	a_div_only_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> state_q == ST_DIV)
		else $error("divider running outside the divide state");
`endif

endmodule

// ===== tb/frame_rate_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame-rate moving average: result checker
// Watches the configuration port and both beat channels, keeps its own
// copy of the duration ring, running sum and frame count, predicts the rate
// of every accepted beat and compares it with the results in order.
// ----------------------------------------------------------------------------
module frame_rate_checker
	import frma_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [TPS_W-1:0]    cfg_wr_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [TICK_W-1:0]   tick_now,
	input  logic                restart,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [RATE_W-1:0]   rate_q8,
	input  logic [FRAMES_W-1:0] frames_in_window,
	input  logic                saturated,
	output int                  pending,
	output int                  mismatches
);

	typedef struct packed {
		logic [RATE_W-1:0]   rate;
		logic [FRAMES_W-1:0] frames;
		logic                sat;
	} frame_rate_t;

	logic [TPS_W-1:0]  tps;
	logic [TICK_W-1:0] durations [WINDOW];
	logic [TICK_W-1:0] prev_tick;
	logic [SUM_W-1:0]  duration_sum;
	int                next_slot;
	int                frames_seen;
	int                errors = 0;
	frame_rate_t       expected_rates [$];

	function automatic void clear_durations();
		foreach (durations[i])
			durations[i] = '0;
		next_slot    = 0;
		frames_seen  = 0;
		duration_sum = '0;
	endfunction

	function automatic frame_rate_t predict_rate(input logic [TICK_W-1:0] tick,
			input logic rst);
		frame_rate_t       r;
		logic [TICK_W-1:0] delta;
		logic [63:0]       scaled;
		logic [63:0]       quot;
		r = '0;
		if (rst) begin
			clear_durations();
			prev_tick = tick;
			return r;
		end
		// The subtraction wraps at 32 bits, so a counter rollover still gives
		// the true duration.
		delta = tick - prev_tick;
		prev_tick = tick;
		duration_sum = duration_sum - durations[next_slot] + delta;
		durations[next_slot] = delta;
		next_slot = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
		if (frames_seen < WINDOW)
			frames_seen++;
		r.frames = FRAMES_W'(frames_seen);
		if (duration_sum == '0) begin
			r.rate = '1;
			r.sat  = 1'b1;
		end else begin
			scaled = (64'(tps) * 64'(frames_seen)) << FRAC_W;
			quot   = scaled / 64'(duration_sum);
			if (quot > 64'hFFFF_FFFF) begin
				r.rate = '1;
				r.sat  = 1'b1;
			end else begin
				r.rate = quot[RATE_W-1:0];
			end
		end
		return r;
	endfunction

	task automatic check_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endtask

	// Results are taken before new beats so that an empty store is never
	// refilled in the same cycle it is checked.
	always @(posedge clk or negedge arst_n) begin
		frame_rate_t want;
		if (!arst_n) begin
			tps = TPS_RESET;
			prev_tick = '0;
			clear_durations();
			expected_rates.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_rates.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual rate %0d",
						$time, rate_q8);
					errors++;
				end else begin
					want = expected_rates.pop_front();
					check_field("rate_q8", want.rate, rate_q8);
					check_field("frames_in_window", want.frames, frames_in_window);
					check_field("saturated", want.sat, saturated);
				end
			end
			if (in_valid && !in_stall)
				expected_rates.push_back(predict_rate(tick_now, restart));
			if (cfg_wr_en)
				tps = cfg_wr_data;
		end
		pending    <= expected_rates.size();
		mismatches <= errors;
	end

endmodule

// ===== tb/frame_rate_moving_average_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame-rate moving average: testbench top
// Drives frame and restart beats with random gaps and output stalls, steps
// ticks_per_second through its extremes between phases, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module frame_rate_moving_average_top_tb;
	import frma_pkg::*;

	localparam int ITEMS_PER_PHASE = 210;
	localparam int SETTLE_CYCLES   = 45;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_LIMIT  = 3000;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [TPS_W-1:0]    cfg_wr_data = '0;
	logic                in_valid    = 1'b0;
	logic [TICK_W-1:0]   tick_now    = '0;
	logic                restart     = 1'b0;
	logic                out_stall   = 1'b0;
	logic                in_stall;
	logic                out_valid;
	logic [RATE_W-1:0]   rate_q8;
	logic [FRAMES_W-1:0] frames_in_window;
	logic                saturated;
	logic                hold_req    = 1'b0;
	bit                  hold_taken  = 1'b0;
	bit                  steady_sender = 1'b0;
	int                  pending;
	int                  mismatches;

	frame_rate_moving_average_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.tick_now         (tick_now),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.rate_q8          (rate_q8),
		.frames_in_window (frames_in_window),
		.saturated        (saturated)
	);

	frame_rate_checker rate_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.tick_now         (tick_now),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.rate_q8          (rate_q8),
		.frames_in_window (frames_in_window),
		.saturated        (saturated),
		.pending          (pending),
		.mismatches       (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// Mostly plausible frame periods, with zero, tiny and near-wrap durations
	// mixed in so the sum reaches zero and its upper bits.
	function automatic logic [TICK_W-1:0] next_delta();
		case ($urandom_range(0, 9))
			0:          return '0;
			1:          return $urandom_range(1, 3);
			2, 3, 4, 5: return $urandom_range(1, 5000);
			6, 7:       return $urandom_range(5001, 1 << 20);
			8:          return $urandom();
			default:    return 32'hFFFF_FFFF - $urandom_range(0, 255);
		endcase
	endfunction

	task automatic send_beat(input logic [TICK_W-1:0] t, input logic rst);
		int gap;
		tick_now <= t;
		restart  <= rst;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = steady_sender ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_rate_config(input logic [TPS_W-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	// Well-formed runs are a restart followed by a burst of frames; about one
	// run in ten is instead a stray frame or a lone restart at an arbitrary tick.
	task automatic run_random(input int n_items, input bit pause_midway);
		int                sent;
		int                frames;
		bit                paused;
		logic [TICK_W-1:0] t;
		sent = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 10) begin
				send_beat($urandom(), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				t = $urandom();
				send_beat(t, 1'b1);
				sent++;
				frames = $urandom_range(1, 24);
				repeat (frames) begin
					t = t + next_delta();
					send_beat(t, 1'b0);
					sent++;
				end
			end
			if (pause_midway && !paused && sent >= n_items / 2) begin
				paused = 1'b1;
				drain();
			end
		end
	endtask

	// Receiver: random stalls, stall-free stretches, and one long hold-off.
	initial begin
		int len;
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 9) < 2) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 100)) @(posedge clk);
			end else begin
				len = idle_len();
				if (len > 0) begin
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [TPS_W-1:0] tps_plan [7];
		tps_plan = '{20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd60,
			TPS_W'($urandom()), TPS_W'($urandom_range(1, 1000000))};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Frames before any restart measure from the reset tick of zero.
		send_beat(32'h0000_0000, 1'b0);
		send_beat(32'd1000, 1'b0);
		// Counter rollover between restart and frame.
		send_beat(32'hFFFF_FFFF, 1'b1);
		send_beat(32'h0000_03E7, 1'b0);
		send_beat(32'h0000_03E7, 1'b0);
		// A single zero duration gives a zero sum.
		send_beat(32'h1234_5678, 1'b1);
		send_beat(32'h1234_5678, 1'b0);
		send_beat(32'h1234_5677, 1'b0);
		// Run past the window so old durations drop out of the sum.
		for (int i = 1; i <= 13; i++)
			send_beat(32'h1234_5677 + 32'(i * 16), 1'b0);
		send_beat(32'h0000_0000, 1'b1);
		send_beat(32'hFFFF_FFFF, 1'b0);
		send_beat(32'hAAAA_AAAA, 1'b0);
		send_beat(32'h5555_5555, 1'b0);
		run_random(ITEMS_PER_PHASE, 1'b0);

		for (int p = 0; p < 7; p++) begin
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_rate_config(tps_plan[p]);
			steady_sender = (p == 0 || p == 4);
			if (p == 0)
				hold_req <= 1'b1;
			run_random(ITEMS_PER_PHASE, p == 2);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
